/* src/dpp_pkg.sv */
// dpp_pkg: shared types and constants of the decoded pixel placement block
// used by every module under src; depends on nothing
package dpp_pkg;

   localparam int DEF_SCREEN_WIDTH  = 800;
   localparam int DEF_SCREEN_HEIGHT = 480;

   localparam int FIELD_W   = 16;  // width of coordinates, color and config words
   localparam int X_W       = 10;  // screen column field width
   localparam int Y_W       = 9;   // screen row field width
   localparam int CSR_IDX_W = 3;

   localparam logic [FIELD_W-1:0] IMAGE_WIDTH_RESET  = 16'd800;
   localparam logic [FIELD_W-1:0] IMAGE_HEIGHT_RESET = 16'd480;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_STRETCH_MODE = 3'd0,
      CSR_OFFSET_X     = 3'd1,
      CSR_OFFSET_Y     = 3'd2,
      CSR_IMAGE_WIDTH  = 3'd3,
      CSR_IMAGE_HEIGHT = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic               stretch_mode;
      logic [FIELD_W-1:0] offset_x;
      logic [FIELD_W-1:0] offset_y;
      logic [FIELD_W-1:0] image_width;
      logic [FIELD_W-1:0] image_height;
   } cfg_type;

   // per-pixel control that rides along the divider chain
   typedef struct packed {
      logic               valid;
      logic               stretch;
      logic               crop_we;
      logic [X_W-1:0]     crop_x;
      logic [Y_W-1:0]     crop_y;
      logic               x_ok;     // start column lies on screen
      logic               x_clip;   // end column reaches the screen edge
      logic               y_ok;
      logic               y_clip;
      logic [FIELD_W-1:0] pixel;
   } side_type;

endpackage

/* src/dpp_prep.sv */
// dpp_prep: input stage, crop placement and stretch numerators
// depends on dpp_pkg
module dpp_prep import dpp_pkg::*; #(
   parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
   parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT,
   parameter int QW            = 10,
   parameter int NUM_W         = FIELD_W + QW
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [FIELD_W-1:0] src_x,
   input  logic [FIELD_W-1:0] src_y,
   input  logic [FIELD_W-1:0] pixel,
   input  cfg_type            cfg,
   output side_type           side_o,
   output logic [NUM_W-1:0]   num_xs_o,
   output logic [NUM_W-1:0]   num_xe_o,
   output logic [NUM_W-1:0]   num_ys_o,
   output logic [NUM_W-1:0]   num_ye_o
);

   localparam int PROD_W = NUM_W + 1;
   localparam int POS_W  = FIELD_W + 2;

   side_type           side_in, side_ff;
   logic [PROD_W-1:0]  prod_x, prod_y, prod_xe, prod_ye;
   logic [NUM_W-1:0]   num_xs_ff, num_xe_ff, num_ys_ff, num_ye_ff;
   logic signed [POS_W-1:0] dx, dy;
   logic               x_in, y_in;

   always_comb begin
      dx = $signed({2'b00, src_x}) + $signed({{2{cfg.offset_x[FIELD_W-1]}}, cfg.offset_x});
      dy = $signed({2'b00, src_y}) + $signed({{2{cfg.offset_y[FIELD_W-1]}}, cfg.offset_y});
      x_in = !dx[POS_W-1] && (dx[POS_W-2:0] < (POS_W-1)'(SCREEN_WIDTH));
      y_in = !dy[POS_W-1] && (dy[POS_W-2:0] < (POS_W-1)'(SCREEN_HEIGHT));

      prod_x  = PROD_W'(src_x) * PROD_W'(SCREEN_WIDTH);
      prod_y  = PROD_W'(src_y) * PROD_W'(SCREEN_HEIGHT);
      prod_xe = prod_x + PROD_W'(SCREEN_WIDTH);
      prod_ye = prod_y + PROD_W'(SCREEN_HEIGHT);

      side_in.valid   = accept;
      side_in.stretch = cfg.stretch_mode;
      side_in.crop_we = x_in && y_in;
      side_in.crop_x  = dx[X_W-1:0];
      side_in.crop_y  = dy[Y_W-1:0];
      // zero image size fails the compare on its own
      side_in.x_ok    = src_x < cfg.image_width;
      side_in.y_ok    = src_y < cfg.image_height;
      side_in.x_clip  = ({1'b0, src_x} + 17'd1) >= {1'b0, cfg.image_width};
      side_in.y_clip  = ({1'b0, src_y} + 17'd1) >= {1'b0, cfg.image_height};
      side_in.pixel   = pixel;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff.valid <= 1'b0;
      end else begin
         side_ff <= side_in;
      end
   end

   always_ff @(posedge clock) begin
      num_xs_ff <= prod_x[NUM_W-1:0];
      num_xe_ff <= prod_xe[NUM_W-1:0];
      num_ys_ff <= prod_y[NUM_W-1:0];
      num_ye_ff <= prod_ye[NUM_W-1:0];
   end

   assign side_o   = side_ff;
   assign num_xs_o = num_xs_ff;
   assign num_xe_o = num_xe_ff;
   assign num_ys_o = num_ys_ff;
   assign num_ye_o = num_ye_ff;

endmodule

/* src/dpp_cell.sv */
// dpp_cell: one restoring division step for all four spans of a pixel
// depends on dpp_pkg
module dpp_cell import dpp_pkg::*; #(
   parameter int QW    = 10,
   parameter int NUM_W = FIELD_W + QW,
   parameter int BIT   = 0
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [FIELD_W-1:0] image_width,
   input  logic [FIELD_W-1:0] image_height,
   input  side_type           side_i,
   input  logic [NUM_W-1:0]   rem_xs_i,
   input  logic [NUM_W-1:0]   rem_xe_i,
   input  logic [NUM_W-1:0]   rem_ys_i,
   input  logic [NUM_W-1:0]   rem_ye_i,
   input  logic [QW-1:0]      q_xs_i,
   input  logic [QW-1:0]      q_xe_i,
   input  logic [QW-1:0]      q_ys_i,
   input  logic [QW-1:0]      q_ye_i,
   output side_type           side_o,
   output logic [NUM_W-1:0]   rem_xs_o,
   output logic [NUM_W-1:0]   rem_xe_o,
   output logic [NUM_W-1:0]   rem_ys_o,
   output logic [NUM_W-1:0]   rem_ye_o,
   output logic [QW-1:0]      q_xs_o,
   output logic [QW-1:0]      q_xe_o,
   output logic [QW-1:0]      q_ys_o,
   output logic [QW-1:0]      q_ye_o
);

   // quotient bit on top, new remainder below
   function automatic logic [NUM_W:0] div_step(input logic [NUM_W-1:0] rem,
                                               input logic [FIELD_W-1:0] d);
      logic [NUM_W-1:0] dsh;
      begin
         dsh = NUM_W'(d) << BIT;
         if (rem >= dsh) begin
            div_step = {1'b1, rem - dsh};
         end else begin
            div_step = {1'b0, rem};
         end
      end
   endfunction

   side_type         side_ff;
   logic [NUM_W:0]   st_xs, st_xe, st_ys, st_ye;
   logic [NUM_W-1:0] rem_xs_ff, rem_xe_ff, rem_ys_ff, rem_ye_ff;
   logic [QW-1:0]    q_xs_in, q_xe_in, q_ys_in, q_ye_in;
   logic [QW-1:0]    q_xs_ff, q_xe_ff, q_ys_ff, q_ye_ff;

   always_comb begin
      st_xs = div_step(rem_xs_i, image_width);
      st_xe = div_step(rem_xe_i, image_width);
      st_ys = div_step(rem_ys_i, image_height);
      st_ye = div_step(rem_ye_i, image_height);
      q_xs_in = q_xs_i;
      q_xe_in = q_xe_i;
      q_ys_in = q_ys_i;
      q_ye_in = q_ye_i;
      q_xs_in[BIT] = st_xs[NUM_W];
      q_xe_in[BIT] = st_xe[NUM_W];
      q_ys_in[BIT] = st_ys[NUM_W];
      q_ye_in[BIT] = st_ye[NUM_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff.valid <= 1'b0;
      end else begin
         side_ff <= side_i;
      end
   end

   always_ff @(posedge clock) begin
      rem_xs_ff <= st_xs[NUM_W-1:0];
      rem_xe_ff <= st_xe[NUM_W-1:0];
      rem_ys_ff <= st_ys[NUM_W-1:0];
      rem_ye_ff <= st_ye[NUM_W-1:0];
      q_xs_ff   <= q_xs_in;
      q_xe_ff   <= q_xe_in;
      q_ys_ff   <= q_ys_in;
      q_ye_ff   <= q_ye_in;
   end

   assign side_o   = side_ff;
   assign rem_xs_o = rem_xs_ff;
   assign rem_xe_o = rem_xe_ff;
   assign rem_ys_o = rem_ys_ff;
   assign rem_ye_o = rem_ye_ff;
   assign q_xs_o   = q_xs_ff;
   assign q_xe_o   = q_xe_ff;
   assign q_ys_o   = q_ys_ff;
   assign q_ye_o   = q_ye_ff;

endmodule

/* src/decoded_pixel_place_crop_or_stretch.sv */
// decoded_pixel_place_crop_or_stretch: top level, registers, divider chain, result stage
// depends on dpp_pkg, dpp_prep, dpp_cell
//
// Places one decoded RGB565 pixel on the screen. In crop mode (stretch_mode 0) the
// pixel moves by the signed offsets and becomes a 1x1 rectangle if it lands on screen.
// In stretch mode the rectangle runs from coord*SCREEN/size to (coord+1)*SCREEN/size,
// clipped to the screen; an empty span, an off-screen start or a zero image size gives
// no write, and then all result fields are zero. A new pixel is taken every clock
// (busy is high during reset and for the first cycle after it, low from then on);
// each transfer gives exactly one result, shown on rsp_* for one cycle with rsp_valid
// once it has passed the input stage, one restoring divider cell for each of the QW
// quotient bits, where QW = max(clog2(SCREEN_WIDTH), clog2(SCREEN_HEIGHT)), and the
// result register. The receiver cannot stall the results. Write configuration only
// while no pixel is in flight; csr_ready is always high and unknown indexes are ignored.
module decoded_pixel_place_crop_or_stretch import dpp_pkg::*; #(
   parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
   parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
   input  logic                 clock,
   input  logic                 reset,
   // pixel input
   input  logic                 start,
   output logic                 busy,
   input  logic [FIELD_W-1:0]   req_src_x,
   input  logic [FIELD_W-1:0]   req_src_y,
   input  logic [FIELD_W-1:0]   req_pixel,
   // rectangle output
   output logic                 rsp_valid,
   output logic                 rsp_write_enable,
   output logic [X_W-1:0]       rsp_x_first,
   output logic [X_W-1:0]       rsp_x_limit,
   output logic [Y_W-1:0]       rsp_y_first,
   output logic [Y_W-1:0]       rsp_y_limit,
   output logic [FIELD_W-1:0]   rsp_fill_color,
   // configuration writes
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [FIELD_W-1:0]   csr_wdata
);

   // quotient bits per division; every start quotient used is below the screen size
   localparam int QX     = $clog2(SCREEN_WIDTH);
   localparam int QY     = $clog2(SCREEN_HEIGHT);
   localparam int QW     = (QX > QY) ? QX : QY;
   localparam int NUM_W  = FIELD_W + QW;
   localparam logic [X_W-1:0] SCREEN_X = X_W'(SCREEN_WIDTH);
   localparam logic [Y_W-1:0] SCREEN_Y = Y_W'(SCREEN_HEIGHT);

   cfg_type cfg_ff;
   logic    busy_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.stretch_mode <= 1'b0;
         cfg_ff.offset_x     <= '0;
         cfg_ff.offset_y     <= '0;
         cfg_ff.image_width  <= IMAGE_WIDTH_RESET;
         cfg_ff.image_height <= IMAGE_HEIGHT_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_STRETCH_MODE: cfg_ff.stretch_mode <= csr_wdata[0];
            CSR_OFFSET_X:     cfg_ff.offset_x     <= csr_wdata;
            CSR_OFFSET_Y:     cfg_ff.offset_y     <= csr_wdata;
            CSR_IMAGE_WIDTH:  cfg_ff.image_width  <= csr_wdata;
            CSR_IMAGE_HEIGHT: cfg_ff.image_height <= csr_wdata;
            default: begin
               // unknown index, write dropped
            end
         endcase
      end
   end

   assign csr_ready = 1'b1;

   // hold off transfers during reset; busy is the registered reset
   always_ff @(posedge clock) begin
      busy_ff <= reset;
   end
   assign busy = busy_ff;

   // chain taps: index 0 is the input stage, index QW the last cell
   side_type         side_c [QW+1];
   logic [NUM_W-1:0] rem_xs [QW+1];
   logic [NUM_W-1:0] rem_xe [QW+1];
   logic [NUM_W-1:0] rem_ys [QW+1];
   logic [NUM_W-1:0] rem_ye [QW+1];
   logic [QW-1:0]    q_xs   [QW+1];
   logic [QW-1:0]    q_xe   [QW+1];
   logic [QW-1:0]    q_ys   [QW+1];
   logic [QW-1:0]    q_ye   [QW+1];

   dpp_prep #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT),
      .QW            (QW),
      .NUM_W         (NUM_W)
   ) u_prep (
      .clock    (clock),
      .reset    (reset),
      .accept   (start && !busy),
      .src_x    (req_src_x),
      .src_y    (req_src_y),
      .pixel    (req_pixel),
      .cfg      (cfg_ff),
      .side_o   (side_c[0]),
      .num_xs_o (rem_xs[0]),
      .num_xe_o (rem_xe[0]),
      .num_ys_o (rem_ys[0]),
      .num_ye_o (rem_ye[0])
   );

   assign q_xs[0] = '0;
   assign q_xe[0] = '0;
   assign q_ys[0] = '0;
   assign q_ye[0] = '0;

   // one cell per quotient bit, most significant first
   for (genvar k = 0; k < QW; k++) begin : g_cell
      dpp_cell #(
         .QW    (QW),
         .NUM_W (NUM_W),
         .BIT   (QW - 1 - k)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .image_width  (cfg_ff.image_width),
         .image_height (cfg_ff.image_height),
         .side_i       (side_c[k]),
         .rem_xs_i     (rem_xs[k]),
         .rem_xe_i     (rem_xe[k]),
         .rem_ys_i     (rem_ys[k]),
         .rem_ye_i     (rem_ye[k]),
         .q_xs_i       (q_xs[k]),
         .q_xe_i       (q_xe[k]),
         .q_ys_i       (q_ys[k]),
         .q_ye_i       (q_ye[k]),
         .side_o       (side_c[k+1]),
         .rem_xs_o     (rem_xs[k+1]),
         .rem_xe_o     (rem_xe[k+1]),
         .rem_ys_o     (rem_ys[k+1]),
         .rem_ye_o     (rem_ye[k+1]),
         .q_xs_o       (q_xs[k+1]),
         .q_xe_o       (q_xe[k+1]),
         .q_ys_o       (q_ys[k+1]),
         .q_ye_o       (q_ye[k+1])
      );
   end

   // result stage
   side_type             side_end;
   logic [QW+X_W-1:0]    qxs_ext, qxe_ext;
   logic [QW+Y_W-1:0]    qys_ext, qye_ext;
   logic                 x_span, y_span, we_in;
   logic [X_W-1:0]       xf_in, xl_in;
   logic [Y_W-1:0]       yf_in, yl_in;
   logic                 rsp_valid_ff;
   logic                 rsp_we_ff;
   logic [X_W-1:0]       rsp_xf_ff, rsp_xl_ff;
   logic [Y_W-1:0]       rsp_yf_ff, rsp_yl_ff;
   logic [FIELD_W-1:0]   rsp_color_ff;

   always_comb begin
      side_end = side_c[QW];
      // zero-extend so the field masks hold for any quotient width
      qxs_ext = {{X_W{1'b0}}, q_xs[QW]};
      qxe_ext = {{X_W{1'b0}}, q_xe[QW]};
      qys_ext = {{Y_W{1'b0}}, q_ys[QW]};
      qye_ext = {{Y_W{1'b0}}, q_ye[QW]};
      // the end never falls below the start, so inequality means a non-empty span
      x_span = side_end.x_ok && (side_end.x_clip || (q_xe[QW] != q_xs[QW]));
      y_span = side_end.y_ok && (side_end.y_clip || (q_ye[QW] != q_ys[QW]));
      if (side_end.stretch) begin
         we_in = x_span && y_span;
         xf_in = qxs_ext[X_W-1:0];
         xl_in = side_end.x_clip ? SCREEN_X : qxe_ext[X_W-1:0];
         yf_in = qys_ext[Y_W-1:0];
         yl_in = side_end.y_clip ? SCREEN_Y : qye_ext[Y_W-1:0];
      end else begin
         we_in = side_end.crop_we;
         xf_in = side_end.crop_x;
         xl_in = side_end.crop_x + X_W'(1);
         yf_in = side_end.crop_y;
         yl_in = side_end.crop_y + Y_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= side_end.valid;
      end
   end

   // no write clears every field
   always_ff @(posedge clock) begin
      rsp_we_ff    <= we_in;
      rsp_xf_ff    <= we_in ? xf_in : '0;
      rsp_xl_ff    <= we_in ? xl_in : '0;
      rsp_yf_ff    <= we_in ? yf_in : '0;
      rsp_yl_ff    <= we_in ? yl_in : '0;
      rsp_color_ff <= we_in ? side_end.pixel : '0;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_write_enable = rsp_we_ff;
   assign rsp_x_first      = rsp_xf_ff;
   assign rsp_x_limit      = rsp_xl_ff;
   assign rsp_y_first      = rsp_yf_ff;
   assign rsp_y_limit      = rsp_yl_ff;
   assign rsp_fill_color   = rsp_color_ff;

endmodule

/* src/dpp_checker.sv */
// dpp_checker: port-level assertions for the placement block, with its bind
// depends on dpp_pkg and decoded_pixel_place_crop_or_stretch
module dpp_checker import dpp_pkg::*; #(
   parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
   parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 start,
   input logic                 busy,
   input logic                 rsp_valid,
   input logic                 rsp_write_enable,
   input logic [X_W-1:0]       rsp_x_first,
   input logic [X_W-1:0]       rsp_x_limit,
   input logic [Y_W-1:0]       rsp_y_first,
   input logic [Y_W-1:0]       rsp_y_limit,
   input logic [FIELD_W-1:0]   rsp_fill_color
);

   localparam int QX  = $clog2(SCREEN_WIDTH);
   localparam int QY  = $clog2(SCREEN_HEIGHT);
   localparam int LAT = ((QX > QY) ? QX : QY) + 2;
   // limits wrap in the field only when the screen fills it
   localparam bit X_NOWRAP = SCREEN_WIDTH < (1 << X_W);
   localparam bit Y_NOWRAP = SCREEN_HEIGHT < (1 << Y_W);

   // every transfer gives one result
   a_latency: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##LAT rsp_valid)
      else $error("missing result after transfer");

   // no result without a transfer that caused it
   a_no_extra: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LAT))
      else $error("result without transfer");

   // no write gives all-zero fields
   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_write_enable |->
         rsp_x_first == '0 && rsp_x_limit == '0 && rsp_y_first == '0 &&
         rsp_y_limit == '0 && rsp_fill_color == '0)
      else $error("no-write result with nonzero fields");

   // a write is a non-empty rectangle
   a_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_write_enable && X_NOWRAP && Y_NOWRAP |->
         rsp_x_first < rsp_x_limit && rsp_y_first < rsp_y_limit)
      else $error("empty rectangle written");

endmodule

bind decoded_pixel_place_crop_or_stretch dpp_checker #(
   .SCREEN_WIDTH  (SCREEN_WIDTH),
   .SCREEN_HEIGHT (SCREEN_HEIGHT)
) u_dpp_checker (.*);

/* tb/testbench.sv */
`timescale 1ns / 100ps
// testbench: self-checking bench for decoded_pixel_place_crop_or_stretch, crop and stretch
// placement checked by a local rectangle predictor; depends on dpp_pkg and the block's RTL
module testbench;
   import dpp_pkg::*;

   localparam int SCR_W          = DEF_SCREEN_WIDTH;
   localparam int SCR_H          = DEF_SCREEN_HEIGHT;
   // input stage, one divider cell per quotient bit, result register
   localparam int PIPE_LATENCY   = ($clog2(SCR_W) > $clog2(SCR_H) ?
                                    $clog2(SCR_W) : $clog2(SCR_H)) + 2;
   localparam int RESET_CYCLES   = 6;
   localparam int MAX_GAP        = 5;
   localparam int RAND_PHASES    = 14;
   localparam int PHASE_PIXELS   = 100;
   localparam int MAX_PRINTED    = 40;
   localparam int CSR_FIRST_UNUSED = CSR_IMAGE_HEIGHT + 1;
   localparam int CSR_LAST_INDEX   = 2 ** CSR_IDX_W - 1;

   // one screen rectangle as the block reports it
   typedef struct packed {
      logic               we;
      logic [X_W-1:0]     x_first;
      logic [X_W-1:0]     x_limit;
      logic [Y_W-1:0]     y_first;
      logic [Y_W-1:0]     y_limit;
      logic [FIELD_W-1:0] color;
   } rect_type;

   localparam rect_type NO_WRITE = '0;

   // one line of the directed stimulus: a register write or a pixel
   typedef struct {
      bit                   is_csr;
      logic [CSR_IDX_W-1:0] idx;
      logic [FIELD_W-1:0]   wdata;
      logic [FIELD_W-1:0]   sx;
      logic [FIELD_W-1:0]   sy;
      logic [FIELD_W-1:0]   px;
      bit                   fixed;    // want typed in by hand
      rect_type             want;
   } dir_row_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   logic [FIELD_W-1:0]   req_src_x = '0;
   logic [FIELD_W-1:0]   req_src_y = '0;
   logic [FIELD_W-1:0]   req_pixel = '0;
   logic                 rsp_valid;
   logic                 rsp_write_enable;
   logic [X_W-1:0]       rsp_x_first;
   logic [X_W-1:0]       rsp_x_limit;
   logic [Y_W-1:0]       rsp_y_first;
   logic [Y_W-1:0]       rsp_y_limit;
   logic [FIELD_W-1:0]   rsp_fill_color;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [FIELD_W-1:0]   csr_wdata = '0;

   cfg_type     shadow_cfg;          // register contents as the block should hold them
   rect_type    pending_rects[$];    // rectangles still owed by the block, oldest first
   dir_row_type dir_rows[$];
   int          mismatch_count = 0;
   int          rsp_count = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   decoded_pixel_place_crop_or_stretch #(
      .SCREEN_WIDTH (SCR_W),
      .SCREEN_HEIGHT(SCR_H)
   ) u_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_src_x       (req_src_x),
      .req_src_y       (req_src_y),
      .req_pixel       (req_pixel),
      .rsp_valid       (rsp_valid),
      .rsp_write_enable(rsp_write_enable),
      .rsp_x_first     (rsp_x_first),
      .rsp_x_limit     (rsp_x_limit),
      .rsp_y_first     (rsp_y_first),
      .rsp_y_limit     (rsp_y_limit),
      .rsp_fill_color  (rsp_fill_color),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   // ---------------------------------------------------------------- predictor

   // nearest-neighbor span on one axis; zero size, off-screen start or empty span fail
   function automatic bit stretch_span(longint coord, longint size, longint screen,
                                       output longint first, output longint limit);
      longint s, e;
      first = 0;
      limit = 0;
      if (size == 0) return 1'b0;
      s = coord * screen / size;
      e = (coord + 1) * screen / size;
      if (s >= screen) return 1'b0;
      if (e > screen) e = screen;   // clip to the screen edge
      if (e <= s) return 1'b0;
      first = s;
      limit = e;
      return 1'b1;
   endfunction

   function automatic rect_type place_pixel(cfg_type c, logic [FIELD_W-1:0] sx,
                                            logic [FIELD_W-1:0] sy, logic [FIELD_W-1:0] px);
      rect_type r;
      longint   dx, dy, xf, xl, yf, yl;
      bit       ok;
      r  = NO_WRITE;
      xf = 0;
      xl = 0;
      yf = 0;
      yl = 0;
      if (!c.stretch_mode) begin
         // crop: shift by signed offsets, 1x1 only when it lands on screen
         dx = longint'(sx) + longint'($signed(c.offset_x));
         dy = longint'(sy) + longint'($signed(c.offset_y));
         ok = dx >= 0 && dx < SCR_W && dy >= 0 && dy < SCR_H;
         xf = dx;
         xl = dx + 1;
         yf = dy;
         yl = dy + 1;
      end else begin
         ok = stretch_span(longint'(sy), longint'(c.image_height), SCR_H, yf, yl) &&
              stretch_span(longint'(sx), longint'(c.image_width), SCR_W, xf, xl);
      end
      // no write leaves every field at zero
      if (ok) begin
         r.we      = 1'b1;
         r.x_first = xf[X_W-1:0];
         r.x_limit = xl[X_W-1:0];
         r.y_first = yf[Y_W-1:0];
         r.y_limit = yl[Y_W-1:0];
         r.color   = px;
      end
      return r;
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(string what, longint got, longint want);
      mismatch_count++;
      if (mismatch_count <= MAX_PRINTED)
         $display("mismatch at result %0d: %s got 'h%0h want 'h%0h",
                  rsp_count, what, got, want);
   endtask

   // results cannot be held off, so every strobe is one transfer
   always @(posedge clock) begin
      rect_type got, want;
      if (!reset && rsp_valid) begin
         got = '{rsp_write_enable, rsp_x_first, rsp_x_limit,
                 rsp_y_first, rsp_y_limit, rsp_fill_color};
         if (pending_rects.size() == 0) begin
            report_mismatch("result with nothing pending", got, 0);
         end else begin
            want = pending_rects.pop_front();
            if (got.we !== want.we)
               report_mismatch("write_enable", got.we, want.we);
            if (got.x_first !== want.x_first)
               report_mismatch("x_first", got.x_first, want.x_first);
            if (got.x_limit !== want.x_limit)
               report_mismatch("x_limit", got.x_limit, want.x_limit);
            if (got.y_first !== want.y_first)
               report_mismatch("y_first", got.y_first, want.y_first);
            if (got.y_limit !== want.y_limit)
               report_mismatch("y_limit", got.y_limit, want.y_limit);
            if (got.color !== want.color)
               report_mismatch("fill_color", got.color, want.color);
         end
         rsp_count++;
      end
   end

   // ---------------------------------------------------------------- driving

   // register transfer; csr_valid stays up so back-to-back writes never toggle it
   // within one step, the next pixel transfer lowers it
   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [FIELD_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_STRETCH_MODE: shadow_cfg.stretch_mode = data[0];
         CSR_OFFSET_X:     shadow_cfg.offset_x     = data;
         CSR_OFFSET_Y:     shadow_cfg.offset_y     = data;
         CSR_IMAGE_WIDTH:  shadow_cfg.image_width  = data;
         CSR_IMAGE_HEIGHT: shadow_cfg.image_height = data;
         default: ;        // unknown index, block ignores it
      endcase
   endtask

   // one pixel transfer after a random gap (none when steady); start stays high into the next
   // pixel when that one comes without a gap
   task automatic send_pixel(logic [FIELD_W-1:0] sx, logic [FIELD_W-1:0] sy,
                             logic [FIELD_W-1:0] px, bit fixed, rect_type fixed_rect,
                             bit steady);
      int gap;
      gap = steady ? 0 : $urandom_range(0, MAX_GAP);
      csr_valid <= 1'b0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start     <= 1'b1;
      req_src_x <= sx;
      req_src_y <= sy;
      req_pixel <= px;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_rects.push_back(fixed ? fixed_rect : place_pixel(shadow_cfg, sx, sy, px));
   endtask

   // registers change only with nothing in flight
   task automatic drain_pipeline();
      start <= 1'b0;
      while (pending_rects.size() != 0) @(posedge clock);
   endtask

   // ---------------------------------------------------------------- stimulus helpers

   function automatic rect_type mk_rect(bit we, int xf, int xl, int yf, int yl,
                                        logic [FIELD_W-1:0] c);
      rect_type r;
      r = '{we, X_W'(xf), X_W'(xl), Y_W'(yf), Y_W'(yl), c};
      return r;
   endfunction

   function automatic void add_csr(logic [CSR_IDX_W-1:0] idx, logic [FIELD_W-1:0] data);
      dir_row_type row;
      row = '{1'b1, idx, data, '0, '0, '0, 1'b0, NO_WRITE};
      dir_rows.push_back(row);
   endfunction

   function automatic void add_pix(logic [FIELD_W-1:0] sx, logic [FIELD_W-1:0] sy,
                                   logic [FIELD_W-1:0] px, bit fixed, rect_type want);
      dir_row_type row;
      row = '{1'b0, '0, '0, sx, sy, px, fixed, want};
      dir_rows.push_back(row);
   endfunction

   // coordinate aimed mostly near the screen (crop) or inside the image (stretch)
   function automatic logic [FIELD_W-1:0] pick_coord(bit stretch, logic [FIELD_W-1:0] off,
                                                     logic [FIELD_W-1:0] size, int screen);
      int target;
      if ($urandom_range(0, 5) == 0) return FIELD_W'($urandom_range(0, 65535));
      if (stretch) return FIELD_W'($urandom_range(0, int'(size) + 1));
      target = int'($urandom_range(0, screen + 80)) - 40;
      return FIELD_W'(target - int'($signed(off)));
   endfunction

   function automatic logic [FIELD_W-1:0] pick_size(int screen);
      case ($urandom_range(0, 9))
         0:       return 16'd1;
         1:       return 16'hFFFF;
         2:       return 16'd0;                   // zero size, never a write in stretch mode
         3:       return FIELD_W'(screen);
         4, 5:    return FIELD_W'($urandom_range(1, 20));
         6, 7:    return FIELD_W'($urandom_range(1, 2 * screen));
         default: return FIELD_W'($urandom_range(1, 65535));
      endcase
   endfunction

   function automatic logic [FIELD_W-1:0] pick_offset();
      case ($urandom_range(0, 7))
         0:       return 16'h0000;
         1:       return 16'h8000;                // most negative
         2:       return FIELD_W'($urandom_range(1, 100));
         3:       return FIELD_W'($urandom_range(0, 65535));
         default: return FIELD_W'(-int'($urandom_range(0, 2000)));
      endcase
   endfunction

   // ---------------------------------------------------------------- run

   initial begin
      bit                 steady;
      logic [FIELD_W-1:0] sx, sy;
      shadow_cfg = '{1'b0, 16'h0000, 16'h0000, IMAGE_WIDTH_RESET, IMAGE_HEIGHT_RESET};

      // reset values: crop, zero offsets, corners and just past the edges
      add_pix(16'd0, 16'd0, 16'hFFFF, 1'b1, mk_rect(1, 0, 1, 0, 1, 16'hFFFF));
      add_pix(16'd799, 16'd479, 16'h1234, 1'b1, mk_rect(1, 799, 800, 479, 480, 16'h1234));
      add_pix(16'd800, 16'd0, 16'hABCD, 1'b1, NO_WRITE);
      add_pix(16'd0, 16'd480, 16'h5555, 1'b1, NO_WRITE);
      add_pix(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, NO_WRITE);
      // most negative offsets
      add_csr(CSR_OFFSET_X, 16'h8000);
      add_csr(CSR_OFFSET_Y, 16'h8000);
      add_pix(16'hFFFF, 16'hFFFF, 16'hA5A5, 1'b1, NO_WRITE);
      add_pix(16'h8000, 16'h8000, 16'h0001, 1'b1, mk_rect(1, 0, 1, 0, 1, 16'h0001));
      add_pix(16'h831F, 16'h81DF, 16'h8001, 1'b1, mk_rect(1, 799, 800, 479, 480, 16'h8001));
      add_pix(16'h7FFF, 16'h8000, 16'h0F0F, 1'b1, NO_WRITE);
      // positive and minus-one offsets, outside the usual range
      add_csr(CSR_OFFSET_X, 16'h7FFF);
      add_csr(CSR_OFFSET_Y, 16'hFFFF);
      add_pix(16'd0, 16'd1, 16'h3C3C, 1'b0, NO_WRITE);
      add_pix(16'h8000, 16'd0, 16'hC3C3, 1'b0, NO_WRITE);
      // centering offsets of a 1600x960 image
      add_csr(CSR_OFFSET_X, 16'hFE70);
      add_csr(CSR_OFFSET_Y, 16'hFF10);
      add_pix(16'd400, 16'd240, 16'h07E0, 1'b1, mk_rect(1, 0, 1, 0, 1, 16'h07E0));
      add_pix(16'd1199, 16'd719, 16'hF800, 1'b1, mk_rect(1, 799, 800, 479, 480, 16'hF800));
      // stretch at the reset image size is one to one
      add_csr(CSR_STRETCH_MODE, 16'h0001);
      add_pix(16'd0, 16'd0, 16'h001F, 1'b1, mk_rect(1, 0, 1, 0, 1, 16'h001F));
      add_pix(16'd799, 16'd479, 16'hFFFF, 1'b1, mk_rect(1, 799, 800, 479, 480, 16'hFFFF));
      add_pix(16'd800, 16'd0, 16'h1111, 1'b1, NO_WRITE);
      // 1x1 image fills the whole screen
      add_csr(CSR_IMAGE_WIDTH, 16'd1);
      add_csr(CSR_IMAGE_HEIGHT, 16'd1);
      add_pix(16'd0, 16'd0, 16'hC0DE, 1'b1, mk_rect(1, 0, 800, 0, 480, 16'hC0DE));
      add_pix(16'd1, 16'd0, 16'h2222, 1'b1, NO_WRITE);
      // largest image: most spans are empty
      add_csr(CSR_IMAGE_WIDTH, 16'hFFFF);
      add_csr(CSR_IMAGE_HEIGHT, 16'hFFFF);
      add_pix(16'd0, 16'd0, 16'h3333, 1'b1, NO_WRITE);
      add_pix(16'hFFFF, 16'hFFFF, 16'h4444, 1'b1, NO_WRITE);
      add_pix(16'd1000, 16'd2000, 16'h6789, 1'b0, NO_WRITE);
      add_csr(CSR_IMAGE_WIDTH, 16'd3);
      add_csr(CSR_IMAGE_HEIGHT, 16'd7);
      add_pix(16'd2, 16'd6, 16'h9ABC, 1'b0, NO_WRITE);
      // zero image size on either axis gives no write
      add_csr(CSR_IMAGE_WIDTH, 16'd0);
      add_pix(16'd0, 16'd0, 16'hDEF0, 1'b1, NO_WRITE);
      add_csr(CSR_IMAGE_WIDTH, 16'd5);
      add_csr(CSR_IMAGE_HEIGHT, 16'd0);
      add_pix(16'd1, 16'd1, 16'h0123, 1'b1, NO_WRITE);
      // unknown register index must leave the registers alone
      add_csr(CSR_IDX_W'(CSR_FIRST_UNUSED), 16'hFFFF);
      add_csr(CSR_IMAGE_HEIGHT, 16'd9);
      add_pix(16'd4, 16'd8, 16'hBEEF, 1'b0, NO_WRITE);

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         if (dir_rows[i].is_csr) begin
            drain_pipeline();
            write_csr(dir_rows[i].idx, dir_rows[i].wdata);
         end else begin
            send_pixel(dir_rows[i].sx, dir_rows[i].sy, dir_rows[i].px,
                       dir_rows[i].fixed, dir_rows[i].want, 1'b0);
         end
      end

      // random phases: fresh settings each time, pixels aimed at the interesting spans
      for (int phase = 0; phase < RAND_PHASES; phase++) begin
         drain_pipeline();
         write_csr(CSR_STRETCH_MODE, FIELD_W'($urandom_range(0, 1)));
         write_csr(CSR_OFFSET_X, pick_offset());
         write_csr(CSR_OFFSET_Y, pick_offset());
         write_csr(CSR_IMAGE_WIDTH, pick_size(SCR_W));
         write_csr(CSR_IMAGE_HEIGHT, pick_size(SCR_H));
         if ($urandom_range(0, 2) == 0)
            write_csr(CSR_IDX_W'($urandom_range(CSR_FIRST_UNUSED, CSR_LAST_INDEX)),
                      FIELD_W'($urandom_range(0, 65535)));
         steady = ($urandom_range(0, 3) == 0);   // some phases run back to back
         for (int n = 0; n < PHASE_PIXELS; n++) begin
            sx = pick_coord(shadow_cfg.stretch_mode, shadow_cfg.offset_x,
                            shadow_cfg.image_width, SCR_W);
            sy = pick_coord(shadow_cfg.stretch_mode, shadow_cfg.offset_y,
                            shadow_cfg.image_height, SCR_H);
            send_pixel(sx, sy, FIELD_W'($urandom_range(0, 65535)), 1'b0, NO_WRITE, steady);
         end
      end

      drain_pipeline();
      // watch for stray strobes after the last result
      repeat (PIPE_LATENCY + 8) @(posedge clock);
      if (pending_rects.size() != 0)
         report_mismatch("results never arrived", pending_rects.size(), 0);
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // hang guard, far beyond the slowest correct run
   initial begin
      #1_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
